[hdl/utk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utk_pkg
// Shared types, constants and helper functions for the UTF-8 word tokenizer.
// ----------------------------------------------------------------------------
package utk_pkg;

  localparam int CP_W    = 21;
  localparam int CNT_W   = 12;
  localparam int LEN_W   = 3;
  localparam int QDEPTH  = 3;
  localparam int QIDX_W  = 2;

  localparam logic [CP_W-1:0]  REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0]  CYR_LO         = 21'h000400;
  localparam logic [CP_W-1:0]  CYR_HI         = 21'h00052F;
  localparam logic [CNT_W-1:0] LIMIT_RST      = 12'd1024;

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  localparam logic [LEN_W-1:0] LEN_BAD = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO = 3'd2;

  typedef struct packed {
    logic             vld;
    logic [CP_W-1:0]  cp;
    logic             err;
    logic [LEN_W-1:0] len;
  } dec_slot_t;

  typedef struct packed {
    dec_slot_t s0;
    dec_slot_t s1;
    logic      eot;
  } dec_out_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic             decode_error;
    logic             is_word_char;
    logic             kept_in_word;
    logic             word_done;
    logic [CNT_W-1:0] word_bytes;
    logic             word_has_cyrillic;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } res_pair_t;

  typedef struct packed {
    result_t          res;
    logic [CNT_W-1:0] cnt;
    logic             cyr;
  } word_step_t;

  function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
    logic [LEN_W-1:0] len;
    if (b < 8'h80)      len = 3'd1;
    else if (b < 8'hC0) len = 3'd0;
    else if (b < 8'hE0) len = 3'd2;
    else if (b < 8'hF0) len = 3'd3;
    else if (b < 8'hF8) len = 3'd4;
    else                len = 3'd0;
    return len;
  endfunction

  function automatic logic in_cyrillic(input logic [CP_W-1:0] cp);
    return (cp >= CYR_LO) && (cp <= CYR_HI);
  endfunction

  function automatic logic word_class(input logic [CP_W-1:0] cp);
    logic wc;
    wc = ((cp >= 21'h30) && (cp <= 21'h39)) ||
         ((cp >= 21'h41) && (cp <= 21'h5A)) ||
         ((cp >= 21'h61) && (cp <= 21'h7A)) ||
         in_cyrillic(cp);
    return wc;
  endfunction

endpackage

[hdl/utk_utf8_dec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utk_utf8_dec
// Byte-serial UTF-8 decoder: sequence state registers and up to two decoded
// slots per byte (replacement for a broken sequence, then the byte's own).
// ----------------------------------------------------------------------------
module utk_utf8_dec
  import utk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       end_of_text,
  output dec_out_t   dec
);

  logic [LEN_W-1:0] exp_r, exp_nxt;
  logic [LEN_W-1:0] got_r, got_nxt;
  logic [CP_W-1:0]  part_r, part_nxt;

  logic [LEN_W-1:0] lead_len;
  logic             lead_multi;
  dec_slot_t        lead_slot;
  logic [CP_W-1:0]  lead_part;
  logic [CP_W-1:0]  cont_part;
  logic [LEN_W-1:0] cont_got;

  always_comb begin
    lead_len   = lead_length(data_byte);
    lead_multi = (lead_len >= LEN_TWO);
    lead_slot  = '0;
    if (lead_len == LEN_BAD) begin
      lead_slot = '{vld: 1'b1, cp: REPLACEMENT_CP, err: 1'b1, len: LEN_ONE};
    end else if (lead_len == LEN_ONE) begin
      lead_slot = '{vld: 1'b1, cp: {13'd0, data_byte}, err: 1'b0, len: LEN_ONE};
    end else if (end_of_text) begin
      lead_slot = '{vld: 1'b1, cp: REPLACEMENT_CP, err: 1'b1, len: LEN_ONE};
    end
    case (lead_len)
      3'd2:    lead_part = {16'd0, data_byte[4:0]};
      3'd3:    lead_part = {17'd0, data_byte[3:0]};
      default: lead_part = {18'd0, data_byte[2:0]};
    endcase
    cont_part = {part_r[CP_W-7:0], data_byte[5:0]};
    cont_got  = got_r + LEN_ONE;
  end

  always_comb begin
    dec      = '0;
    dec.eot  = end_of_text;
    exp_nxt  = exp_r;
    got_nxt  = got_r;
    part_nxt = part_r;
    if (exp_r == '0) begin
      dec.s1 = lead_slot;
      if (lead_multi) begin
        exp_nxt  = lead_len;
        got_nxt  = LEN_ONE;
        part_nxt = lead_part;
      end
    end else if ((data_byte & CONT_MASK) == CONT_TAG) begin
      if (cont_got >= exp_r) begin
        dec.s1   = '{vld: 1'b1, cp: cont_part, err: 1'b0, len: exp_r};
        exp_nxt  = '0;
        got_nxt  = '0;
        part_nxt = '0;
      end else if (end_of_text) begin
        dec.s1   = '{vld: 1'b1, cp: REPLACEMENT_CP, err: 1'b1, len: cont_got};
        exp_nxt  = '0;
        got_nxt  = '0;
        part_nxt = '0;
      end else begin
        got_nxt  = cont_got;
        part_nxt = cont_part;
      end
    end else begin
      dec.s0   = '{vld: 1'b1, cp: REPLACEMENT_CP, err: 1'b1, len: got_r};
      dec.s1   = lead_slot;
      exp_nxt  = '0;
      got_nxt  = '0;
      part_nxt = '0;
      if (lead_multi) begin
        exp_nxt  = lead_len;
        got_nxt  = LEN_ONE;
        part_nxt = lead_part;
      end
    end
    if (end_of_text) begin
      exp_nxt  = '0;
      got_nxt  = '0;
      part_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= '0;
      got_r  <= '0;
      part_r <= '0;
    end else if (fire) begin
      exp_r  <= exp_nxt;
      got_r  <= got_nxt;
      part_r <= part_nxt;
    end
  end

endmodule

[hdl/utk_word_cls.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utk_word_cls
// Word classifier: running kept byte count and Cyrillic flag, applied to the
// decoded slots of one byte in order, with end-of-text close.
// ----------------------------------------------------------------------------
module utk_word_cls
  import utk_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [CNT_W-1:0] limit,
  input  dec_out_t         dec,
  output res_pair_t        pair
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cyr_r, cyr_nxt;

  word_step_t       st0, st1;
  logic [CNT_W-1:0] mid_cnt;
  logic             mid_cyr;
  logic [CNT_W-1:0] end_cnt;
  logic             end_cyr;

  function automatic word_step_t step(input dec_slot_t s, input logic [CNT_W-1:0] c,
                                      input logic f, input logic [CNT_W-1:0] lim);
    word_step_t o;
    logic [CNT_W:0] sum;
    o     = '0;
    sum   = {1'b0, c} + {{(CNT_W+1-LEN_W){1'b0}}, s.len};
    o.res.code_point   = s.cp;
    o.res.decode_error = s.err;
    o.res.is_word_char = word_class(s.cp);
    o.cnt = c;
    o.cyr = f;
    if (o.res.is_word_char) begin
      if (sum < {1'b0, lim}) begin
        o.res.kept_in_word = 1'b1;
        o.cnt = sum[CNT_W-1:0];
        o.cyr = f | in_cyrillic(s.cp);
      end
      o.res.word_bytes        = o.cnt;
      o.res.word_has_cyrillic = o.cyr;
    end else begin
      o.res.word_bytes        = c;
      o.res.word_has_cyrillic = f;
      o.res.word_done         = (c != '0);
      o.cnt = '0;
      o.cyr = 1'b0;
    end
    return o;
  endfunction

  always_comb begin
    st0     = step(dec.s0, cnt_r, cyr_r, limit);
    mid_cnt = dec.s0.vld ? st0.cnt : cnt_r;
    mid_cyr = dec.s0.vld ? st0.cyr : cyr_r;
    st1     = step(dec.s1, mid_cnt, mid_cyr, limit);
    end_cnt = dec.s1.vld ? st1.cnt : mid_cnt;
    end_cyr = dec.s1.vld ? st1.cyr : mid_cyr;

    pair = '0;
    if (dec.s0.vld && dec.s1.vld) begin
      pair.cnt    = 2'd2;
      pair.first  = st0.res;
      pair.second = st1.res;
      pair.second.last = 1'b1;
      pair.second.word_done = st1.res.word_done | (dec.eot && (end_cnt != '0));
    end else if (dec.s0.vld || dec.s1.vld) begin
      pair.cnt   = 2'd1;
      pair.first = dec.s0.vld ? st0.res : st1.res;
      pair.first.last = 1'b1;
      pair.first.word_done = pair.first.word_done | (dec.eot && (end_cnt != '0));
    end

    cnt_nxt = dec.eot ? '0 : end_cnt;
    cyr_nxt = dec.eot ? 1'b0 : end_cyr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      cyr_r <= 1'b0;
    end else if (fire) begin
      cnt_r <= cnt_nxt;
      cyr_r <= cyr_nxt;
    end
  end

endmodule

[hdl/utk_res_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utk_res_queue
// Three-entry result queue: takes up to two results per cycle while room is
// high, hands one result per beat to the output port.
// ----------------------------------------------------------------------------
module utk_res_queue
  import utk_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  res_pair_t pair,
  input  logic      pop,
  output logic      room,
  output logic      head_vld,
  output result_t   head
);

  result_t    q_r   [QDEPTH];
  result_t    q_nxt [QDEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] cnt_left;
  logic [QIDX_W-1:0] wr0, wr1;

  always_comb begin
    q_nxt    = q_r;
    cnt_left = cnt_r - {1'b0, pop};
    if (pop) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
    end
    wr0 = cnt_left[QIDX_W-1:0];
    wr1 = cnt_left[QIDX_W-1:0] + 2'd1;
    cnt_nxt = cnt_left;
    if (push) begin
      if (pair.cnt != 2'd0) q_nxt[wr0] = pair.first;
      if (pair.cnt == 2'd2) q_nxt[wr1] = pair.second;
      cnt_nxt = cnt_left + pair.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign room     = (cnt_r <= 2'd1);
  assign head_vld = (cnt_r != 2'd0);
  assign head     = q_r[0];

endmodule

[hdl/utf8_word_tokenizer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_word_tokenizer_top
// UTF-8 decoder with word tokenizer: one text byte in per beat, zero to two
// classified code point results out per byte.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while in_tready is high (the queue holds
// at most one result). Decode and word classification finish in the cycle the
// byte is accepted and results land in the three-entry result queue, so a byte
// giving one result passes at one byte per cycle while out_tready is high. A
// byte giving two results (a broken sequence, then a new lead) needs two output
// beats, since the output port moves one result per cycle. Bytes that only start
// a multi-byte sequence give no result. cfg_wr_data sets the word byte limit
// (reset 1024); the user must write it only while the block is idle, unchecked.
module utf8_word_tokenizer_top
  import utk_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] data_byte
  input  logic             in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  logic             out_tready,
  // [20:0] code_point, [21] kept_in_word, [22] word_done, [34:23] word_bytes,
  // [35] word_has_cyrillic, [39:36] zero
  output logic [39:0]      out_tdata,
  output logic [1:0]       out_tuser,  // [0] decode_error, [1] is_word_char
  output logic             out_tlast   // last
);

  logic [CNT_W-1:0] limit_r;
  logic             in_fire;
  logic             out_fire;
  logic             room;
  dec_out_t         dec;
  res_pair_t        pair;
  result_t          head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  assign in_tready = room;
  assign in_fire   = in_tvalid & room;
  assign out_fire  = out_tvalid & out_tready;

  utk_utf8_dec u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (in_fire),
    .data_byte   (in_tdata),
    .end_of_text (in_tlast),
    .dec         (dec)
  );

  utk_word_cls u_word (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .limit (limit_r),
    .dec   (dec),
    .pair  (pair)
  );

  utk_res_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_fire),
    .pair     (pair),
    .pop      (out_fire),
    .room     (room),
    .head_vld (out_tvalid),
    .head     (head)
  );

  assign out_tdata = {4'd0, head.word_has_cyrillic, head.word_bytes, head.word_done,
                      head.kept_in_word, head.code_point};
  assign out_tuser = {head.is_word_char, head.decode_error};
  assign out_tlast = head.last;

endmodule

[bench/tb_utf8_word_tokenizer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_word_tokenizer_top
// Self-checking bench for the UTF-8 word tokenizer. Bytes of text go in as
// stream beats. A scoreboard class decodes every accepted byte on its own and
// queues the classified code points that it should cause. Each result beat
// is checked field by field against the oldest queued result. A short
// directed text comes first. Random text follows under several word byte
// limits: mostly well-formed UTF-8, with noise, broken sequences and early
// end of text mixed in. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_utf8_word_tokenizer_top;
  import utk_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_BYTES = 220;
  localparam int NUM_PHASES  = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
  } text_beat_t;

  class token_scoreboard;
    logic [CNT_W-1:0] byte_limit;
    logic [LEN_W-1:0] seq_len;
    logic [LEN_W-1:0] seq_got;
    logic [CP_W-1:0]  seq_cp;
    logic [CNT_W-1:0] run_bytes;
    logic             run_cyr;
    result_t          batch[$];
    result_t          expected_results[$];
    int               mismatches;

    function new();
      byte_limit = LIMIT_RST;
      seq_len    = '0;
      seq_got    = '0;
      seq_cp     = '0;
      run_bytes  = '0;
      run_cyr    = 1'b0;
      mismatches = 0;
    endfunction

    function void set_limit(logic [CNT_W-1:0] v);
      byte_limit = v;
    endfunction

    function void clear_seq();
      seq_len = '0;
      seq_got = '0;
      seq_cp  = '0;
    endfunction

    function logic [LEN_W-1:0] seq_length(logic [7:0] b);
      casez (b)
        8'b0???????: return 3'd1;
        8'b10??????: return 3'd0;
        8'b110?????: return 3'd2;
        8'b1110????: return 3'd3;
        8'b11110???: return 3'd4;
        default:     return 3'd0;
      endcase
    endfunction

    function logic cyrillic(logic [CP_W-1:0] cp);
      return (cp >= CYR_LO) && (cp <= CYR_HI);
    endfunction

    function logic word_char(logic [CP_W-1:0] cp);
      return (cp >= 21'h30 && cp <= 21'h39) || (cp >= 21'h41 && cp <= 21'h5A) ||
             (cp >= 21'h61 && cp <= 21'h7A) || cyrillic(cp);
    endfunction

    function void classify(logic [CP_W-1:0] cp, logic err, logic [LEN_W-1:0] len);
      result_t r;
      int      total;
      r = '0;
      r.code_point   = cp;
      r.decode_error = err;
      r.is_word_char = word_char(cp);
      if (r.is_word_char) begin
        total = int'(run_bytes) + int'(len);
        if (total < int'(byte_limit)) begin
          r.kept_in_word = 1'b1;
          run_bytes      = total[CNT_W-1:0];
          if (cyrillic(cp)) run_cyr = 1'b1;
        end
        r.word_bytes        = run_bytes;
        r.word_has_cyrillic = run_cyr;
      end else begin
        r.word_bytes        = run_bytes;
        r.word_has_cyrillic = run_cyr;
        r.word_done         = (run_bytes != '0);
        run_bytes           = '0;
        run_cyr             = 1'b0;
      end
      batch.push_back(r);
    endfunction

    function void start_seq(logic [7:0] b, logic eot);
      logic [LEN_W-1:0] n;
      n = seq_length(b);
      if (n == 3'd0) begin
        classify(REPLACEMENT_CP, 1'b1, 3'd1);
      end else if (n == 3'd1) begin
        classify({13'd0, b}, 1'b0, 3'd1);
      end else begin
        seq_cp  = {13'd0, b & (8'hFF >> n)};
        seq_len = n;
        seq_got = 3'd1;
        if (eot) begin
          clear_seq();
          classify(REPLACEMENT_CP, 1'b1, 3'd1);
        end
      end
    endfunction

    // predict the results of one accepted byte
    function void decode_byte(logic [7:0] b, logic eot);
      logic [CP_W-1:0]  cp;
      logic [LEN_W-1:0] len;
      batch.delete();
      if (seq_len == '0) begin
        start_seq(b, eot);
      end else if (b[7:6] == 2'b10) begin
        seq_cp  = {seq_cp[CP_W-7:0], b[5:0]};
        seq_got = seq_got + 3'd1;
        if (seq_got >= seq_len) begin
          cp  = seq_cp;
          len = seq_len;
          clear_seq();
          classify(cp, 1'b0, len);
        end else if (eot) begin
          len = seq_got;
          clear_seq();
          classify(REPLACEMENT_CP, 1'b1, len);
        end
      end else begin
        len = seq_got;
        clear_seq();
        classify(REPLACEMENT_CP, 1'b1, len);
        start_seq(b, eot);
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      if (eot) begin
        if (run_bytes != '0 && batch.size() > 0) batch[batch.size()-1].word_done = 1'b1;
        run_bytes = '0;
        run_cyr   = 1'b0;
        clear_seq();
      end
      foreach (batch[i]) expected_results.push_back(batch[i]);
    endfunction

    function void compare(string field, logic [CP_W-1:0] e, logic [CP_W-1:0] a);
      if (e !== a) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, e, a);
      end
    endfunction

    function void check_result(logic [39:0] tdata, logic [1:0] tuser, logic tlast);
      result_t e;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0h tlast %0b",
                 $time, tdata, tuser, tlast);
        return;
      end
      e = expected_results.pop_front();
      compare("code_point", e.code_point, tdata[20:0]);
      compare("decode_error", CP_W'(e.decode_error), CP_W'(tuser[0]));
      compare("is_word_char", CP_W'(e.is_word_char), CP_W'(tuser[1]));
      compare("kept_in_word", CP_W'(e.kept_in_word), CP_W'(tdata[21]));
      compare("word_done", CP_W'(e.word_done), CP_W'(tdata[22]));
      compare("word_bytes", CP_W'(e.word_bytes), CP_W'(tdata[34:23]));
      compare("word_has_cyrillic", CP_W'(e.word_has_cyrillic), CP_W'(tdata[35]));
      compare("last", CP_W'(e.last), CP_W'(tlast));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;
  logic             in_tlast = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [39:0]      out_tdata;   // [20:0] code_point, [21] kept_in_word, [22] word_done,
                                 // [34:23] word_bytes, [35] word_has_cyrillic, [39:36] zero
  logic [1:0]       out_tuser;   // [0] decode_error, [1] is_word_char
  logic             out_tlast;

  token_scoreboard sb = new();
  text_beat_t      text_q[$];
  logic            in_idle = 1'b0;
  logic            out_idle = 1'b0;
  int              cycle_count = 0;

  utf8_word_tokenizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // result side: stall a random number of cycles, then take one beat
  initial begin
    int stall;
    forever begin
      stall = out_idle ? $urandom_range(0, 19) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  task automatic send_text();
    int gap;
    foreach (text_q[i]) begin
      gap = in_idle ? $urandom_range(0, 19) : 0;
      @(negedge clk);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_tvalid = 1'b1;
      in_tdata  = text_q[i].data;
      in_tlast  = text_q[i].eot;
      do @(posedge clk); while (!in_tready);
      sb.decode_byte(text_q[i].data, text_q[i].eot);
    end
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_word_limit(input logic [CNT_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_limit(v);
  endtask

  function automatic void put(input logic [7:0] b, input logic eot = 1'b0);
    text_beat_t t;
    t.data = b;
    t.eot  = eot;
    text_q.push_back(t);
  endfunction

  function automatic void put_lead(input int need);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = 8'hFF << (8 - need);
    lo = 8'hFF >> (need + 1);
    put(hi | (8'($urandom_range(0, 255)) & lo));
  endfunction

  function automatic void put_cont(input int count);
    for (int k = 0; k < count; k++) put({2'b10, 6'($urandom_range(0, 63))});
  endfunction

  function automatic void add_char();
    int              sel;
    int              need;
    logic [CP_W-1:0] cp;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      case ($urandom_range(0, 2))
        0:       put(8'($urandom_range(8'h30, 8'h39)));
        1:       put(8'($urandom_range(8'h41, 8'h5A)));
        default: put(8'($urandom_range(8'h61, 8'h7A)));
      endcase
    end else if (sel < 45) begin
      put(8'($urandom_range(0, 127)));
    end else if (sel < 60) begin
      cp = 21'($urandom_range(CYR_LO, CYR_HI));
      put({3'b110, cp[10:6]});
      put({2'b10, cp[5:0]});
    end else if (sel < 85) begin
      need = (sel < 68) ? 2 : (sel < 78) ? 3 : 4;
      put_lead(need);
      put_cont(need - 1);
    end else if (sel < 92) begin
      put(8'($urandom_range(0, 255)));
    end else begin
      // truncated sequence; the next character breaks it
      need = $urandom_range(2, 4);
      put_lead(need);
      put_cont($urandom_range(0, need - 2));
    end
  endfunction

  initial begin
    logic [CNT_W-1:0] limits[NUM_PHASES];
    limits = '{12'd4095, 12'd1, 12'd0, 12'd5, 12'd12, 12'd3, 12'd2, LIMIT_RST};
    limits[5] = 12'($urandom_range(3, 40));
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // digit range ends, 'A', 'z', the Cyrillic top, each sequence length,
    // bad leads, a broken sequence and text ending mid-sequence
    text_q.delete();
    put(8'h41); put(8'h7A); put(8'h30); put(8'h39); put(8'h20);
    put(8'h00); put(8'hFF); put(8'h80);
    put(8'hD0); put(8'h90); put(8'hD4); put(8'hAF);
    put(8'hE2); put(8'h82); put(8'hAC);
    put(8'hF0); put(8'h9F); put(8'h98); put(8'h80);
    put(8'hC3); put(8'h41);
    put(8'hE2); put(8'h82, 1'b1);
    put(8'hC3, 1'b1);
    send_text();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_word_limit(limits[p]);
      in_idle  = (p % 4 == 1) || (p % 4 == 3);
      out_idle = (p % 4 == 2) || (p % 4 == 3);
      text_q.delete();
      while (text_q.size() < PHASE_BYTES) add_char();
      foreach (text_q[i]) text_q[i].eot = ($urandom_range(0, 29) == 0);
      text_q[text_q.size()-1].eot = 1'b1;
      send_text();
    end

    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
